/* rtl/core/tlpt_pkg.sv */
// ============================================================================
// tlpt_pkg: shared types and constants for the two-level page table engine
// Item structs, action codes, address constants and controller commands.
// ============================================================================
package tlpt_pkg;

  localparam int DEF_TABLE_SLOTS       = 16;
  localparam int DEF_ENTRIES_PER_TABLE = 1024;
  localparam int DIR_COUNT             = 1024;
  localparam int IDX_W                 = 10;

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [31:0] KSPACE_START   = 32'hC000_0000;
  localparam logic [31:0] SCRATCH_PAGE   = 32'hC03F_F000;
  localparam logic [31:0] RECURSIVE_BASE = 32'hFFC0_0000;
  localparam logic [9:0]  KERNEL_DIR     = 10'd768;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr_in;
    logic        map_writable;
    logic        map_user;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] phys_addr_out;
    logic        eff_writable;
    logic        eff_user;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic init_step;  // clear one directory entry after reset
    logic load;       // capture input item, start directory read
    logic tbl_rd;     // issue table read at item index
    logic decide;     // evaluate entry, perform write, latch result
    logic clr_step;   // clear one entry of the new table
    logic scan_step;  // read one entry of the table for empty check
    logic scan_chk;   // look at scanned entry
    logic release_t;  // free directory entry and slot
  } tlpt_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_clear; // map needs a fresh table (clear sweep)
    logic need_scan;  // unmap succeeded, empty check needed
    logic cnt_last;   // sweep counter at last entry
    logic dir_last;   // sweep counter at last directory entry
    logic found;      // scanned entry was present
  } tlpt_sts_t;

endpackage

/* rtl/core/tlpt_datapath.sv */
// ============================================================================
// tlpt_datapath: page table storage and per-item evaluation
// Directory memory, table memory, both with registered read, slot pool.
// ============================================================================
module tlpt_datapath import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
  parameter int ENTRIES_PER_TABLE = DEF_ENTRIES_PER_TABLE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      enabled,
  input  in_item_t  item,
  input  tlpt_cmd_t cmd,
  output tlpt_sts_t sts,
  output out_item_t result
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int DEPTH  = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int DIR_W  = SLOT_W + 2;

  // directory entry: slot, user, present
  logic [DIR_W-1:0] dir_mem [DIR_COUNT];
  logic [DIR_W-1:0] dir_rd_r;
  logic [TABLE_SLOTS-1:0] used_r;

  // table entry: frame(20), user, writable, present
  logic [22:0] mem [DEPTH];
  logic [22:0] rd_r;

  in_item_t    it_r;
  logic        dp_r, du_r;
  logic [SLOT_W-1:0] ds_r;
  logic [SLOT_W-1:0] fslot_r;
  logic        ffree_r;
  logic [IDX_W-1:0] cnt_r;
  logic        need_clear_r, need_scan_r;
  out_item_t   res_r;
  out_item_t   res_nxt;

  logic [9:0]  di, ti;
  logic        map_bad, unmap_bad, q_bad;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] fs;
  logic        ff;

  assign di = it_r.virt_addr[31:22];
  assign ti = it_r.virt_addr[21:12];
  assign slot = need_clear_r ? fslot_r : ds_r;

  assign map_bad = (it_r.virt_addr[11:0] != 12'd0) || (it_r.phys_addr_in[11:0] != 12'd0)
    || (it_r.virt_addr == SCRATCH_PAGE) || (it_r.virt_addr >= RECURSIVE_BASE)
    || (it_r.map_user && it_r.virt_addr >= KSPACE_START)
    || (!it_r.map_user && it_r.virt_addr < KSPACE_START);
  assign unmap_bad = (it_r.virt_addr[11:0] != 12'd0) || (it_r.virt_addr >= RECURSIVE_BASE);
  assign q_bad = it_r.virt_addr >= RECURSIVE_BASE;

  // lowest free slot
  always_comb begin
    fs = '0;
    ff = 1'b0;
    for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        fs = SLOT_W'(k);
        ff = 1'b1;
      end
    end
  end

  // Clocked memory access
  logic [ADDR_W-1:0] waddr, raddr;
  logic [22:0]       wdata;
  logic              we;

  always_comb begin
    we    = 1'b0;
    waddr = {slot, ti};
    wdata = '0;
    raddr = {slot, ti};
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = {slot, cnt_r};
    end
    if (cmd.scan_step) raddr = {slot, cnt_r};
    if (cmd.decide && enabled) begin
      if (it_r.action == ACT_MAP && !map_bad && (dp_r || ffree_r) && !rd_r[0]) begin
        we    = 1'b1;
        wdata = {it_r.phys_addr_in[31:12], it_r.map_user, it_r.map_writable, 1'b1};
      end else if (it_r.action == ACT_UNMAP && !unmap_bad && dp_r && rd_r[0]) begin
        we    = 1'b1;
        wdata = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // directory write port: reset sweep, allocation, user bit, release
  logic             dir_we;
  logic [IDX_W-1:0] dir_waddr;
  logic [DIR_W-1:0] dir_wdata;

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = di;
    dir_wdata = '0;
    if (cmd.init_step) begin
      dir_we    = 1'b1;
      dir_waddr = cnt_r;
    end
    if (cmd.decide && enabled && it_r.action == ACT_MAP && !map_bad) begin
      if (!dp_r && ffree_r) begin
        dir_we    = 1'b1;
        dir_wdata = {fslot_r, it_r.map_user, 1'b1};
      end else if (dp_r && it_r.map_user) begin
        dir_we    = 1'b1;
        dir_wdata = {ds_r, 1'b1, 1'b1};
      end
    end
    if (cmd.release_t) dir_we = 1'b1;
  end

  // directory is read at the accepting edge, from the incoming item
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (cmd.load) dir_rd_r <= dir_mem[item.virt_addr[31:22]];
  end

  // result of the decide step
  always_comb begin
    res_nxt = '0;
    if (enabled) begin
      case (it_r.action)
        ACT_MAP: begin
          if (!map_bad) res_nxt.ok = dp_r ? !rd_r[0] : ffree_r;
        end
        ACT_UNMAP: begin
          if (!unmap_bad && dp_r && rd_r[0]) begin
            res_nxt.ok = 1'b1;
            res_nxt.phys_addr_out = {rd_r[22:3], 12'd0};
          end
        end
        ACT_QUERY: begin
          if (!q_bad && dp_r && rd_r[0]) begin
            res_nxt.ok = 1'b1;
            res_nxt.phys_addr_out = {rd_r[22:3], it_r.virt_addr[11:0]};
            res_nxt.eff_writable = rd_r[1];
            res_nxt.eff_user = rd_r[2] && du_r;
          end
        end
        default: ;
      endcase
    end
  end

  logic clear_rd;
  // a freshly allocated table reads as empty even before the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      need_clear_r <= 1'b0;
      need_scan_r <= 1'b0;
      cnt_r <= '0;
      clear_rd <= 1'b0;
    end else begin
      if (cmd.load) begin
        it_r    <= item;
        fslot_r <= fs;
        ffree_r <= ff;
        need_scan_r <= 1'b0;
        need_clear_r <= 1'b0;
      end
      if (cmd.tbl_rd) begin
        dp_r <= dir_rd_r[0];
        du_r <= dir_rd_r[1];
        ds_r <= dir_rd_r[DIR_W-1:2];
        need_clear_r <= enabled && it_r.action == ACT_MAP && !map_bad
                        && !dir_rd_r[0] && ffree_r;
        cnt_r <= '0;
      end
      clear_rd <= cmd.tbl_rd && !dir_rd_r[0];
      if (cmd.clr_step || cmd.init_step) cnt_r <= cnt_r + 1'b1;
      if (cmd.decide) begin
        res_r <= res_nxt;
        cnt_r <= '0;
        if (enabled && it_r.action == ACT_MAP && !map_bad && !dp_r && ffree_r)
          used_r[fslot_r] <= 1'b1;
        need_scan_r <= (it_r.action == ACT_UNMAP) && res_nxt.ok && (di != KERNEL_DIR);
      end
      if (cmd.scan_step) cnt_r <= cnt_r + 1'b1;
      if (cmd.release_t) begin
        used_r[ds_r] <= 1'b0;
        need_scan_r <= 1'b0;
      end
    end
  end

  assign sts.need_clear = need_clear_r;
  assign sts.need_scan  = need_scan_r;
  assign sts.cnt_last   = (cnt_r == IDX_W'(ENTRIES_PER_TABLE - 1));
  assign sts.dir_last   = (cnt_r == IDX_W'(DIR_COUNT - 1));
  assign sts.found      = rd_r[0] && !clear_rd;
  assign result         = res_r;

endmodule

/* rtl/core/tlpt_ctrl.sv */
// ============================================================================
// tlpt_ctrl: sequencer for the page table engine
// Reset sweep, then per item: lookup, optional table clear, update and scan.
// ============================================================================
module tlpt_ctrl import tlpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  tlpt_sts_t sts,
  output tlpt_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIR   = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_INIT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin  // directory clear sweep after reset
        cmd.init_step = 1'b1;
        if (sts.dir_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_DIR;
      end
      S_DIR: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_CLR;
      end
      S_CLR: begin
        if (sts.need_clear) begin
          cmd.clr_step = 1'b1;
          if (sts.cnt_last) state_nxt = S_RD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_DEC;  // registered read of the entry
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (sts.need_scan) begin
          cmd.scan_step = 1'b1;
          last_nxt  = sts.cnt_last;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CHK: begin
        if (sts.found) begin
          state_nxt = S_OUT;
        end else if (last_r) begin
          cmd.release_t = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          last_nxt = sts.cnt_last;
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

/* rtl/core/two_level_page_table_engine.sv */
// ============================================================================
// two_level_page_table_engine: x86-style two-level page table
// Map, unmap and query on a directory of 1024 entries and a table pool.
// ============================================================================
// Usage:
//  - Input channel in_valid/in_stall/in_item carries one action item.
//  - Result channel out_valid/out_stall/out_item returns one item per input.
//  - cfg_we/cfg_wdata write the enable bit; write only while idle.
// Timing: one item at a time; the next item is taken at the earliest in the
//  cycle after the result leaves. Items that neither allocate nor scan a
//  table step through the DIR, CLR, RD, DEC and SCAN states to OUT. A map
//  that allocates a table first clears it, one entry per cycle. An unmap
//  that succeeds outside the kernel directory scans the table for present
//  entries, one read a cycle, ending early at the first present entry.
// Reset: enable cleared, all slots free. The directory memory is then
//  cleared by a sweep over all DIR_COUNT entries with in_stall high. Table
//  memory is not swept; tables are cleared when allocated.
// Stall: the result holds in its register while out_stall is high and no
//  new item is taken until it leaves.
// ============================================================================
module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
  parameter int ENTRIES_PER_TABLE = DEF_ENTRIES_PER_TABLE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      enabled_r;
  tlpt_cmd_t cmd;
  tlpt_sts_t sts;

  // enable register
  always_ff @(posedge clk) begin
    if (!rst_n) enabled_r <= 1'b0;
    else if (cfg_we) enabled_r <= cfg_wdata;
  end

  tlpt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  tlpt_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS), .ENTRIES_PER_TABLE(ENTRIES_PER_TABLE)
  ) u_dp (
    .clk, .rst_n, .enabled(enabled_r), .item(in_item), .cmd, .sts,
    .result(out_item)
  );

endmodule

/* test/two_level_page_table_engine_test.sv */
// ============================================================================
// two_level_page_table_engine_test: self-checking bench for the page table
// Drives map, unmap and query items through the valid/stall channels, keeps
// its own model of the directory, the table pool and the enable bit, and
// checks every result item in order against it. Directed cases first, then
// random phases with varied sender gaps and receiver stalls.
// ============================================================================
module two_level_page_table_engine_test;
  import tlpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = DEF_TABLE_SLOTS;
  localparam int PER_TABLE = DEF_ENTRIES_PER_TABLE;
  localparam logic [1:0] ACT_BAD = 2'd3;      // undefined action code
  localparam int IDLE_LIMIT = 20000;          // cycles without any handshake
  localparam int RANDOM_ITEMS = 540;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  two_level_page_table_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow page table: directory, slot pool, table memory, enable bit
  // ---------------------------------------------------------------------------
  logic        pt_enabled;
  logic        dir_present [DIR_COUNT];
  logic        dir_user    [DIR_COUNT];
  int          dir_slot    [DIR_COUNT];
  logic        slot_busy   [SLOTS];
  logic [31:0] pte_mem     [SLOTS*PER_TABLE];  // frame | U<<2 | W<<1 | P

  out_item_t   result_q[$];    // results still owed by the block
  logic [31:0] mapped_va_q[$]; // pages mapped at some point, for hits
  logic [9:0]  dir_pick[24];   // small directory set so the pool fills up

  int errors, n_items, n_ok, n_results;
  int gap_pct, stall_pct;

  function automatic out_item_t translate(in_item_t it);
    out_item_t   r;
    logic [31:0] va, e;
    logic [9:0]  di, ti;
    int          s, k;
    logic        busy;
    r = '0;
    va = it.virt_addr;
    di = va[31:22];
    ti = va[21:12];
    if (!pt_enabled) return r;
    case (it.action)
      ACT_MAP: begin
        if (va[11:0] != 0 || it.phys_addr_in[11:0] != 0 || va == SCRATCH_PAGE ||
            va >= RECURSIVE_BASE || (it.map_user && va >= KSPACE_START) ||
            (!it.map_user && va < KSPACE_START)) return r;
        if (!dir_present[di]) begin
          // lowest free slot gets the new table
          for (s = 0; s < SLOTS; s++) if (!slot_busy[s]) break;
          if (s >= SLOTS) return r;
          slot_busy[s] = 1'b1;
          for (k = 0; k < PER_TABLE; k++) pte_mem[s*PER_TABLE + k] = '0;
          dir_present[di] = 1'b1;
          dir_user[di] = it.map_user;
          dir_slot[di] = s;
        end else if (it.map_user) begin
          dir_user[di] = 1'b1;   // sticks even if the page turns out present
        end
        s = dir_slot[di];
        if (pte_mem[s*PER_TABLE + ti][0]) return r;
        pte_mem[s*PER_TABLE + ti] = {it.phys_addr_in[31:12], 9'd0, it.map_user,
                                     it.map_writable, 1'b1};
        mapped_va_q.push_back(va);
        r.ok = 1'b1;
      end
      ACT_UNMAP: begin
        if (va[11:0] != 0 || va >= RECURSIVE_BASE || !dir_present[di]) return r;
        s = dir_slot[di];
        e = pte_mem[s*PER_TABLE + ti];
        if (!e[0]) return r;
        pte_mem[s*PER_TABLE + ti] = '0;
        r.ok = 1'b1;
        r.phys_addr_out = {e[31:12], 12'd0};
        if (di == KERNEL_DIR) return r;
        busy = 1'b0;
        for (k = 0; k < PER_TABLE; k++) busy |= pte_mem[s*PER_TABLE + k][0];
        if (!busy) begin
          // table emptied: hand it back to the pool
          dir_present[di] = 1'b0;
          dir_user[di] = 1'b0;
          slot_busy[s] = 1'b0;
        end
      end
      ACT_QUERY: begin
        if (va >= RECURSIVE_BASE || !dir_present[di]) return r;
        e = pte_mem[dir_slot[di]*PER_TABLE + ti];
        if (!e[0]) return r;
        r.ok = 1'b1;
        r.phys_addr_out = {e[31:12], va[11:0]};
        r.eff_writable = e[1];
        r.eff_user = e[2] & dir_user[di];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched with the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ok=%0b pa=%h w=%0b u=%0b", $time,
                 out_item.ok, out_item.phys_addr_out, out_item.eff_writable,
                 out_item.eff_user);
      end else begin
        exp_r = result_q.pop_front();
        if (out_item.ok !== exp_r.ok) begin
          errors++;
          $display("%0t: ok expected %0b actual %0b", $time, exp_r.ok, out_item.ok);
        end
        if (out_item.phys_addr_out !== exp_r.phys_addr_out) begin
          errors++;
          $display("%0t: phys_addr_out expected %h actual %h", $time,
                   exp_r.phys_addr_out, out_item.phys_addr_out);
        end
        if (out_item.eff_writable !== exp_r.eff_writable) begin
          errors++;
          $display("%0t: eff_writable expected %0b actual %0b", $time,
                   exp_r.eff_writable, out_item.eff_writable);
        end
        if (out_item.eff_user !== exp_r.eff_user) begin
          errors++;
          $display("%0t: eff_user expected %0b actual %0b", $time,
                   exp_r.eff_user, out_item.eff_user);
        end
      end
    end
  end

  // Receiver stalls, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: an unmap scan of an empty table is the longest quiet stretch.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers; all called at a falling edge and return at one
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    result_q.push_back(translate(it));   // predicted at the handshake
    n_items++;
    n_ok += int'(result_q[$].ok);
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] act, logic [31:0] va, logic [31:0] pa,
                         logic w, logic u);
    in_item_t it;
    it.action = act;
    it.virt_addr = va;
    it.phys_addr_in = pa;
    it.map_writable = w;
    it.map_user = u;
    send_item(it);
  endtask

  // Block is idle once nothing is owed; a short margin covers the handshake.
  task automatic drain();
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_enable(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    pt_enabled = v;
  endtask

  // Random item: mostly well-formed actions on a small directory set, with
  // hits on earlier mappings, plus some raw noise.
  function automatic in_item_t make_item();
    in_item_t   it;
    logic [9:0] di, ti;
    int         r;
    r = $urandom_range(0, 99);
    it.action = 2'($urandom_range(0, 3));
    it.virt_addr = $urandom;
    it.phys_addr_in = $urandom;
    it.map_writable = 1'($urandom_range(0, 1));
    it.map_user = 1'($urandom_range(0, 1));
    if (r < 8) return it;
    if (r < 10) begin
      it.action = ACT_MAP;
      it.virt_addr = SCRATCH_PAGE;
      return it;
    end
    r = $urandom_range(0, 99);
    it.action = (r < 40) ? ACT_MAP : (r < 70) ? ACT_UNMAP : (r < 96) ? ACT_QUERY : ACT_BAD;
    di = dir_pick[$urandom_range(0, 23)];
    ti = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 5));
    it.virt_addr = {di, ti, 12'd0};
    if (it.action != ACT_MAP && mapped_va_q.size() > 0 && $urandom_range(0, 1))
      it.virt_addr = mapped_va_q[$urandom_range(0, mapped_va_q.size() - 1)];
    if (it.action == ACT_QUERY) it.virt_addr[11:0] = 12'($urandom);
    if ($urandom_range(0, 19) != 0) it.phys_addr_in[11:0] = '0;
    it.map_user = (it.virt_addr < KSPACE_START);
    if ($urandom_range(0, 9) == 0) it.map_user = ~it.map_user;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_disabled();
    send_op(ACT_MAP, 32'hC000_0000, 32'h0010_0000, 1'b1, 1'b0);
    send_op(ACT_UNMAP, 32'hC000_0000, '0, 1'b0, 1'b0);
    send_op(ACT_QUERY, 32'hC000_0123, '0, 1'b0, 1'b0);
  endtask

  task automatic test_map_rejects();
    send_op(ACT_MAP, 32'hC000_0004, 32'h0010_0000, 1'b1, 1'b0);  // va unaligned
    send_op(ACT_MAP, 32'hC000_1000, 32'h0010_0800, 1'b1, 1'b0);  // pa unaligned
    send_op(ACT_MAP, SCRATCH_PAGE, 32'h0010_0000, 1'b1, 1'b0);
    send_op(ACT_MAP, RECURSIVE_BASE, 32'h0010_0000, 1'b1, 1'b0);
    send_op(ACT_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 1'b1, 1'b0);
    send_op(ACT_MAP, 32'hC000_2000, 32'h0010_0000, 1'b1, 1'b1);  // user in kernel
    send_op(ACT_MAP, 32'h0040_0000, 32'h0010_0000, 1'b1, 1'b0);  // kernel in user
    send_op(ACT_BAD, 32'hC000_0000, 32'h0010_0000, 1'b1, 1'b1);
  endtask

  task automatic test_map_lifecycle();
    // kernel directory keeps its table after the last unmap
    send_op(ACT_MAP, 32'hC000_0000, 32'hFFFF_F000, 1'b1, 1'b0);
    send_op(ACT_MAP, 32'hC000_0000, 32'h0000_0000, 1'b0, 1'b0);  // already present
    send_op(ACT_QUERY, 32'hC000_0FFF, '0, 1'b0, 1'b0);
    send_op(ACT_UNMAP, 32'hC000_0000, '0, 1'b0, 1'b0);
    send_op(ACT_UNMAP, 32'hC000_0000, '0, 1'b0, 1'b0);           // now absent
    send_op(ACT_UNMAP, 32'hC000_0010, '0, 1'b0, 1'b0);           // unaligned
    // user table is released once empty
    send_op(ACT_MAP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    send_op(ACT_MAP, 32'h003F_F000, 32'h1234_5000, 1'b1, 1'b1);
    send_op(ACT_QUERY, 32'h003F_FABC, '0, 1'b0, 1'b0);
    send_op(ACT_UNMAP, 32'h003F_F000, '0, 1'b0, 1'b0);
    send_op(ACT_UNMAP, 32'h0000_0000, '0, 1'b0, 1'b0);
    send_op(ACT_QUERY, 32'h0000_0000, '0, 1'b0, 1'b0);
    send_op(ACT_QUERY, 32'hFFC0_0000, '0, 1'b0, 1'b0);
  endtask

  task automatic run_phase(int gap, int stall, int count);
    gap_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();   // sender holds off until all results are in
      send_item(make_item());
    end
  endtask

  task automatic test_random();
    run_phase(0, 0, 135);
    run_phase(67, 0, 135);
    set_enable(1'b0);
    run_phase(0, 67, 10);     // everything rejected while disabled
    set_enable(1'b1);
    run_phase(0, 67, 125);
    run_phase(14, 14, 135);
  endtask

  initial begin
    errors = 0;
    n_items = 0;
    n_ok = 0;
    n_results = 0;
    gap_pct = 0;
    stall_pct = 0;
    pt_enabled = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    for (int d = 0; d < DIR_COUNT; d++) begin
      dir_present[d] = 1'b0;
      dir_user[d] = 1'b0;
      dir_slot[d] = 0;
    end
    for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
    dir_pick = '{10'd0, 10'd1, 10'd2, 10'd255, 10'd511, 10'd766, 10'd767,
                 10'd768, 10'd769, 10'd770, 10'd1020, 10'd1021, 10'd1022,
                 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
                 10'd0, 10'd0, 10'd0};
    for (int p = 14; p < 24; p++) dir_pick[p] = 10'($urandom_range(3, 1019));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_disabled();
    set_enable(1'b1);
    test_map_rejects();
    test_map_lifecycle();
    test_random();

    drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d items (%0d succeeded, %0d results checked) across",
             n_items, n_ok, n_results);
    $display("enable toggling, pool exhaustion and four idle/stall mixes.");
    if (errors == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
